>>> hw/rtl/svm_pkg.sv
// Shared types and constants of the sample playback voice mixer.
package svm_pkg;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_NOTE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam int MEM_AW    = 12;
	localparam int FRAC_BITS = 12;
	localparam int MIX_BIAS  = 512;
	localparam int MIX_MAX   = 1023;

	localparam logic [15:0] POS_IDLE   = 16'hffff;
	localparam logic [7:0]  LAST_CLAIM = 8'hff;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLAIM,
		ST_FETCH,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic [14:0]       step;
		logic [15:0]       phase;
		logic [7:0]        last;
		logic signed [6:0] value;
		logic [15:0]       pos;
	} voice_t;

	typedef struct packed {
		logic busy;
		logic accept;
		logic scan;
		logic claim;
		logic apply;
		logic last;
	} ctrl_t;

endpackage

>>> hw/rtl/svm_sample_mem.sv
// Sample memory: one write port, one registered read port.
module svm_sample_mem
	import svm_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [MEM_AW-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [MEM_AW-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [2**MEM_AW];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/svm_voice_alu.sv
// Shared voice datapath: phase advance, fetch decision, halving, mix accumulation and
// the position compare used when a voice is claimed.
module svm_voice_alu
	import svm_pkg::*;
#(
	parameter int SAMPLE_LEN = 4096,
	parameter int ACC_W      = 12
) (
	input  voice_t                   cur,
	input  logic [15:0]              best,
	input  logic [7:0]               rdata,
	input  logic signed [ACC_W-1:0]  acc_in,
	output voice_t                   nxt,
	output logic                     greater,
	output logic signed [ACC_W-1:0]  acc_out
);

	localparam logic [15:0] LEN = 16'(SAMPLE_LEN);

	logic [16:0]       sum;
	logic              active;
	logic              fetch;
	logic signed [7:0] sample;
	logic signed [7:0] rounded;
	logic signed [7:0] half;

	always_comb begin
		sum     = {1'b0, cur.phase} + {2'b0, cur.step};
		active  = cur.pos < LEN;
		fetch   = cur.last != {3'b0, sum[16:FRAC_BITS]};
		sample  = $signed(rdata);
		// Adding one to a negative value before the shift makes the halving truncate
		// toward zero.
		rounded = sample + $signed({7'b0, rdata[7]});
		half    = rounded >>> 1;

		nxt = cur;
		if (active) begin
			if (fetch) begin
				nxt.value = half[6:0];
				nxt.pos   = cur.pos + 16'd1;
			end
			nxt.phase = sum[15:0];
			nxt.last  = {4'b0, sum[15:FRAC_BITS]};
		end

		acc_out = acc_in + $signed({{(ACC_W-7){nxt.value[6]}}, nxt.value});
		greater = cur.pos > best;
	end

endmodule

>>> hw/rtl/sample_playback_voice_mixer.sv
// Top level of the sample playback voice mixer: sequencer, voice state and sample memory.
//
// A transaction is taken when start is high and busy is low. A load writes the sample
// memory in the accepting cycle and busy stays low. A note-on keeps busy high while
// the voices are scanned one per cycle for the largest position and while the pick is claimed.
// A tick keeps busy high while each voice passes a fetch state for the sample memory
// read and an apply state for its update through the single voice datapath. The mixed
// sample appears on mixed_sample, with done high for a single cycle, in the first cycle
// that busy is low; the receiver cannot stall it, and a new transaction may be taken in
// that same cycle. No clearing pass follows reset.
module sample_playback_voice_mixer
	import svm_pkg::*;
#(
	parameter int SAMPLE_LEN = 4096,
	parameter int VOICES     = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [11:0]       sample_address,
	input  logic signed [7:0] sample_byte,
	input  logic [14:0]       tone_step,
	output logic              done,
	output logic [9:0]        mixed_sample
);

	localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int ACC_W = $clog2(MIX_BIAS + 64 * VOICES) + 2;
	localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);

	state_t state_q, state_d;
	ctrl_t  ctrl;

	voice_t                  voice_q [VOICES];
	logic [VW-1:0]           vidx_q;
	logic [VW-1:0]           pick_q;
	logic [15:0]             best_q;
	logic [14:0]             step_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    done_q;
	logic [9:0]              mix_q;

	voice_t                  cur;
	voice_t                  nxt;
	logic                    greater;
	logic signed [ACC_W-1:0] acc_out;
	logic [7:0]              rdata;
	logic [9:0]              mix_sat;

	assign cur = voice_q[vidx_q];

	svm_sample_mem u_mem (
		.clk   (clk),
		.we    (ctrl.accept && (command == CMD_LOAD)),
		.waddr (sample_address),
		.wdata (sample_byte),
		.raddr (cur.pos[MEM_AW-1:0]),
		.rdata (rdata)
	);

	svm_voice_alu #(
		.SAMPLE_LEN (SAMPLE_LEN),
		.ACC_W      (ACC_W)
	) u_alu (
		.cur     (cur),
		.best    (best_q),
		.rdata   (rdata),
		.acc_in  (acc_q),
		.nxt     (nxt),
		.greater (greater),
		.acc_out (acc_out)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (command)
						CMD_NOTE: state_d = ST_SCAN;
						CMD_TICK: state_d = ST_FETCH;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (vidx_q == LAST_V) begin
					state_d = ST_CLAIM;
				end
			end
			ST_CLAIM: state_d = ST_IDLE;
			ST_FETCH: state_d = ST_APPLY;
			ST_APPLY: begin
				state_d = (vidx_q == LAST_V) ? ST_IDLE : ST_FETCH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.busy   = state_q != ST_IDLE;
		ctrl.accept = start && (state_q == ST_IDLE);
		ctrl.scan   = state_q == ST_SCAN;
		ctrl.claim  = state_q == ST_CLAIM;
		ctrl.apply  = state_q == ST_APPLY;
		ctrl.last   = vidx_q == LAST_V;
	end

	always_comb begin
		if (acc_out < $signed(ACC_W'(0))) begin
			mix_sat = 10'd0;
		end else if (acc_out > $signed(ACC_W'(MIX_MAX))) begin
			mix_sat = 10'(MIX_MAX);
		end else begin
			mix_sat = acc_out[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vidx_q  <= '0;
			done_q  <= 1'b0;
			for (int v = 0; v < VOICES; v++) begin
				voice_q[v] <= '{step: 15'd0, phase: 16'd0, last: 8'd0, value: 7'sd0,
					pos: POS_IDLE};
			end
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (ctrl.accept) begin
				vidx_q <= '0;
			end else if ((ctrl.scan || ctrl.apply) && !ctrl.last) begin
				vidx_q <= vidx_q + VW'(1);
			end
			if (ctrl.claim) begin
				voice_q[pick_q].step  <= step_q;
				voice_q[pick_q].phase <= 16'd0;
				voice_q[pick_q].last  <= LAST_CLAIM;
				voice_q[pick_q].pos   <= 16'd0;
			end
			if (ctrl.apply) begin
				voice_q[vidx_q] <= nxt;
				if (ctrl.last) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			best_q <= 16'd0;
			pick_q <= '0;
			step_q <= tone_step;
			acc_q  <= ACC_W'(MIX_BIAS);
		end
		// Strictly greater keeps the lowest numbered voice on a tie.
		if (ctrl.scan && greater) begin
			best_q <= cur.pos;
			pick_q <= vidx_q;
		end
		if (ctrl.apply) begin
			acc_q <= acc_out;
			if (ctrl.last) begin
				mix_q <= mix_sat;
			end
		end
	end

	assign busy         = ctrl.busy;
	assign done         = done_q;
	assign mixed_sample = mix_q;

endmodule

>>> hw/rtl/svm_checker.sv
// Port-level checker of the sample playback voice mixer and its bind statement.
module svm_checker
	import svm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] command,
	input logic       done
);

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_TICK)) |=> busy)
		else $error("tick transaction did not raise busy");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_LOAD)) |=> (!busy && !done))
		else $error("load transaction raised busy or a result");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a transaction");

endmodule

bind sample_playback_voice_mixer svm_checker u_svm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.command (command),
	.done    (done)
);
